@@ rtl/smalu_pkg.sv @@
// Shared types and constants for the sign-magnitude 128-bit ALU.
package smalu_pkg;

    localparam int MagW  = 128;
    localparam int LenW  = 8;
    localparam int CntW  = 7;
    localparam int SInW  = 272;
    localparam int SOutW = 264;

    typedef enum logic [3:0] {
        OP_ADD = 4'd0,
        OP_SUB = 4'd1,
        OP_MUL = 4'd2,
        OP_DIV = 4'd3,
        OP_CMP = 4'd4,
        OP_AND = 4'd5,
        OP_OR  = 4'd6,
        OP_XOR = 4'd7,
        OP_SHL = 4'd8,
        OP_SHR = 4'd9,
        OP_NEG = 4'd10,
        OP_ABS = 4'd11
    } opcode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ALU,
        ST_SUB2,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } state_t;

    localparam logic [1:0] ORD_LT = 2'b11;
    localparam logic [1:0] ORD_EQ = 2'b00;
    localparam logic [1:0] ORD_GT = 2'b01;

    typedef struct packed {
        logic sub;
    } au_ctl_t;

    typedef struct packed {
        logic carry;
        logic zero;
    } au_stat_t;

endpackage

@@ rtl/smalu_addsub.sv @@
// Shared 128-bit adder/subtractor with carry and zero status.
module smalu_addsub (
    input  logic [smalu_pkg::MagW-1:0] x,
    input  logic [smalu_pkg::MagW-1:0] y,
    input  smalu_pkg::au_ctl_t         ctl,
    output logic [smalu_pkg::MagW-1:0] sum,
    output smalu_pkg::au_stat_t        stat
);
    import smalu_pkg::*;

    logic [MagW:0] full;

    // carry set on subtract means no borrow, i.e. x >= y
    assign full       = {1'b0, x} + {1'b0, y ^ {MagW{ctl.sub}}} + {{MagW{1'b0}}, ctl.sub};
    assign sum        = full[MagW-1:0];
    assign stat.carry = full[MagW];
    assign stat.zero  = (full[MagW-1:0] == '0);

endmodule

@@ rtl/int128_sign_magnitude_alu.sv @@
// Top level of the sign-magnitude 128-bit ALU: sequencer, operand and result registers.
//
// Channel | Dir | Handshake           | Content
// s_      | in  | s_tvalid / s_tready | s_tuser opcode, s_tdata operands and shift distance
// m_      | out | m_tvalid / m_tready | m_tdata result, remainder and compare order
//
// Simple ops pass through ST_ALU and ST_DONE after accept; sub with a larger b adds ST_SUB2.
// Mul and div with ordinary operands run a set-up state, 128 passes through the shared
// 128-bit adder, one bit a pass, and the final state. s_tready returns with the result.
// aresetn is synchronous, active low, and clears the sequencer and output valid.
// s_tready is high only while idle; a result held by m_tready stalls the next
// one in the final state, while the output register can hold an earlier one.
module int128_sign_magnitude_alu #(
    parameter int MAX_BITS = 128
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // a_neg, a_overflow, a_nan, a_hi, a_lo, b_neg, b_overflow, b_nan, b_hi, b_lo,
    // shift_amount, zero fill
    input  logic [smalu_pkg::SInW-1:0]  s_tdata,
    // opcode
    input  logic [3:0]                  s_tuser,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // res_neg, res_overflow, res_nan, res_hi, res_lo, rem_neg, rem_hi, rem_lo,
    // order, zero fill
    output logic [smalu_pkg::SOutW-1:0] m_tdata
);
    import smalu_pkg::*;

    state_t              state_reg, state_next;
    logic [CntW-1:0]     cnt_reg, cnt_next;
    logic [3:0]          op_reg, op_next;
    logic                a_neg_reg, a_ovf_reg, a_nan_reg;
    logic                a_neg_next, a_ovf_next, a_nan_next;
    logic                b_neg_reg, b_ovf_reg, b_nan_reg;
    logic                b_neg_next, b_ovf_next, b_nan_next;
    logic [MagW-1:0]     a_m_reg, a_m_next, b_m_reg, b_m_next;
    logic [7:0]          sh_reg, sh_next;
    logic [MagW-1:0]     acc_reg, acc_next, mcand_reg, mcand_next, mplier_reg, mplier_next;
    logic [LenW-1:0]     la_reg, la_next, lb_reg, lb_next;
    logic                r_neg_reg, r_ovf_reg, r_nan_reg, rem_neg_reg;
    logic                r_neg_next, r_ovf_next, r_nan_next, rem_neg_next;
    logic [MagW-1:0]     r_m_reg, r_m_next, rem_m_reg, rem_m_next;
    logic [1:0]          ord_reg, ord_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [SOutW-1:0]    m_tdata_reg, m_tdata_next;

    logic [MagW-1:0]     au_x, au_y, au_sum;
    au_ctl_t             au_ctl;
    au_stat_t            au_stat;

    logic                s_fire, out_free, last;
    logic                mrg_ovf, mrg_nan, a_zero, b_zero, same_sign, div_take;
    logic [MagW-1:0]     rm_shift;

    smalu_addsub u_addsub (
        .x    (au_x),
        .y    (au_y),
        .ctl  (au_ctl),
        .sum  (au_sum),
        .stat (au_stat)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign last      = (cnt_reg == {CntW{1'b1}});
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    assign mrg_ovf   = a_ovf_reg || b_ovf_reg;
    assign mrg_nan   = a_nan_reg || b_nan_reg;
    assign a_zero    = !a_ovf_reg && !a_nan_reg && (a_m_reg == '0);
    assign b_zero    = !b_ovf_reg && !b_nan_reg && (b_m_reg == '0);
    assign same_sign = (a_neg_reg == b_neg_reg);
    assign rm_shift  = {acc_reg[MagW-2:0], mcand_reg[MagW-1]};
    assign div_take  = acc_reg[MagW-1] || au_stat.carry;

    // shared unit operand selection
    always_comb begin
        au_x       = a_m_reg;
        au_y       = b_m_reg;
        au_ctl.sub = 1'b1;
        case (state_reg)
            ST_ALU: begin
                au_ctl.sub = !((op_reg == OP_ADD || op_reg == OP_SUB) && same_sign);
            end
            ST_SUB2: begin
                au_x = b_m_reg;
                au_y = a_m_reg;
            end
            ST_MUL: begin
                au_x       = acc_reg;
                au_y       = mplier_reg[0] ? mcand_reg : '0;
                au_ctl.sub = 1'b0;
            end
            ST_DIV: begin
                au_x = rm_shift;
            end
            default: ;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_fire) state_next = ST_ALU;
            ST_ALU: begin
                state_next = ST_DONE;
                case (op_reg)
                    OP_ADD, OP_SUB: begin
                        if (!mrg_ovf && !mrg_nan && !same_sign && !au_stat.carry)
                            state_next = ST_SUB2;
                    end
                    OP_MUL: begin
                        if (!a_zero && !b_zero && !mrg_ovf && !mrg_nan) state_next = ST_MUL;
                    end
                    OP_DIV: begin
                        if (!mrg_ovf && !mrg_nan && (b_m_reg != '0)) state_next = ST_DIV;
                    end
                    default: ;
                endcase
            end
            ST_SUB2: state_next = ST_DONE;
            ST_MUL:  if (last) state_next = ST_DONE;
            ST_DIV:  if (last) state_next = ST_DONE;
            ST_DONE: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cnt_next      = cnt_reg;
        op_next       = op_reg;
        a_neg_next    = a_neg_reg;
        a_ovf_next    = a_ovf_reg;
        a_nan_next    = a_nan_reg;
        b_neg_next    = b_neg_reg;
        b_ovf_next    = b_ovf_reg;
        b_nan_next    = b_nan_reg;
        a_m_next      = a_m_reg;
        b_m_next      = b_m_reg;
        sh_next       = sh_reg;
        acc_next      = acc_reg;
        mcand_next    = mcand_reg;
        mplier_next   = mplier_reg;
        la_next       = la_reg;
        lb_next       = lb_reg;
        r_neg_next    = r_neg_reg;
        r_ovf_next    = r_ovf_reg;
        r_nan_next    = r_nan_reg;
        r_m_next      = r_m_reg;
        rem_neg_next  = rem_neg_reg;
        rem_m_next    = rem_m_reg;
        ord_next      = ord_reg;
        m_tdata_next  = m_tdata_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    op_next    = s_tuser;
                    a_neg_next = s_tdata[0];
                    a_ovf_next = s_tdata[1];
                    a_nan_next = s_tdata[2];
                    a_m_next   = {s_tdata[66:3], s_tdata[130:67]};
                    // subtract is add with b's sign flipped
                    b_neg_next = s_tdata[131] ^ (s_tuser == OP_SUB);
                    b_ovf_next = s_tdata[132];
                    b_nan_next = s_tdata[133];
                    b_m_next   = {s_tdata[197:134], s_tdata[261:198]};
                    sh_next    = s_tdata[269:262];
                end
            end
            ST_ALU: begin
                r_neg_next   = 1'b0;
                r_ovf_next   = 1'b0;
                r_nan_next   = 1'b0;
                r_m_next     = '0;
                rem_neg_next = 1'b0;
                rem_m_next   = '0;
                ord_next     = ORD_EQ;
                cnt_next     = '0;
                acc_next     = '0;
                mcand_next   = a_m_reg;
                mplier_next  = b_m_reg;
                la_next      = '0;
                lb_next      = '0;
                case (op_reg)
                    OP_ADD, OP_SUB: begin
                        r_neg_next = a_neg_reg;
                        r_ovf_next = mrg_ovf;
                        r_nan_next = mrg_nan;
                        r_m_next   = a_m_reg;
                        if (!mrg_ovf && !mrg_nan) begin
                            r_m_next = au_sum;
                            if (same_sign) r_ovf_next = au_stat.carry;
                        end
                    end
                    OP_MUL: begin
                        r_neg_next = a_neg_reg;
                        r_ovf_next = a_ovf_reg;
                        r_nan_next = a_nan_reg;
                        if (a_zero || b_zero) begin
                            r_m_next = '0;
                        end else begin
                            r_ovf_next = mrg_ovf;
                            r_nan_next = mrg_nan;
                            r_m_next   = a_m_reg;
                        end
                    end
                    OP_DIV: begin
                        if (mrg_ovf) r_ovf_next = 1'b1;
                        else if (mrg_nan || (b_m_reg == '0)) r_nan_next = 1'b1;
                        mplier_next = '0;
                    end
                    OP_CMP: begin
                        if (a_ovf_reg || a_nan_reg) ord_next = ORD_LT;
                        else if (b_ovf_reg || b_nan_reg) ord_next = ORD_GT;
                        else if (!same_sign) ord_next = a_neg_reg ? ORD_LT : ORD_GT;
                        else if (au_stat.zero) ord_next = ORD_EQ;
                        else if (au_stat.carry ^ a_neg_reg) ord_next = ORD_GT;
                        else ord_next = ORD_LT;
                    end
                    OP_AND, OP_OR, OP_XOR: begin
                        r_neg_next = a_neg_reg;
                        r_ovf_next = mrg_ovf;
                        r_nan_next = mrg_nan;
                        r_m_next   = a_m_reg;
                        if (!mrg_ovf && !mrg_nan) begin
                            if (op_reg == OP_AND) r_m_next = a_m_reg & b_m_reg;
                            else if (op_reg == OP_OR) r_m_next = a_m_reg | b_m_reg;
                            else r_m_next = a_m_reg ^ b_m_reg;
                        end
                    end
                    OP_SHL, OP_SHR: begin
                        r_ovf_next = a_ovf_reg;
                        r_nan_next = a_nan_reg;
                        if ({1'b0, sh_reg} > 9'(MAX_BITS)) begin
                            r_neg_next = 1'b0;
                            r_m_next   = '0;
                        end else begin
                            r_neg_next = a_neg_reg;
                            r_m_next   = (op_reg == OP_SHL) ? (a_m_reg << sh_reg)
                                                            : (a_m_reg >> sh_reg);
                        end
                    end
                    OP_NEG, OP_ABS: begin
                        r_neg_next = (op_reg == OP_NEG) ? !a_neg_reg : 1'b0;
                        r_ovf_next = a_ovf_reg;
                        r_nan_next = a_nan_reg;
                        r_m_next   = a_m_reg;
                    end
                    default: ;
                endcase
            end
            ST_SUB2: begin
                r_m_next   = au_sum;
                r_neg_next = b_neg_reg;
            end
            ST_MUL: begin
                acc_next    = au_sum;
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                cnt_next    = cnt_reg + 1'b1;
                la_next     = a_m_reg[cnt_reg] ? LenW'(cnt_reg) + 1'b1 : la_reg;
                lb_next     = b_m_reg[cnt_reg] ? LenW'(cnt_reg) + 1'b1 : lb_reg;
                if (last) begin
                    if ((a_m_reg[MagW-1:64] != '0 && b_m_reg[MagW-1:64] != '0) ||
                        ({1'b0, la_next} + {1'b0, lb_next} > 9'(MAX_BITS))) begin
                        r_ovf_next = 1'b1;
                    end else begin
                        r_neg_next = a_neg_reg ^ b_neg_reg;
                        r_m_next   = au_sum;
                    end
                end
            end
            ST_DIV: begin
                acc_next    = div_take ? au_sum : rm_shift;
                mcand_next  = mcand_reg << 1;
                mplier_next = {mplier_reg[MagW-2:0], div_take};
                cnt_next    = cnt_reg + 1'b1;
                if (last) begin
                    r_neg_next   = a_neg_reg ^ b_neg_reg;
                    r_m_next     = mplier_next;
                    rem_neg_next = a_neg_reg;
                    rem_m_next   = acc_next;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {2'b00, ord_reg, rem_m_reg[63:0], rem_m_reg[MagW-1:64],
                                     rem_neg_reg, r_m_reg[63:0], r_m_reg[MagW-1:64],
                                     r_nan_reg, r_ovf_reg, r_neg_reg};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg     <= cnt_next;
        op_reg      <= op_next;
        a_neg_reg   <= a_neg_next;
        a_ovf_reg   <= a_ovf_next;
        a_nan_reg   <= a_nan_next;
        b_neg_reg   <= b_neg_next;
        b_ovf_reg   <= b_ovf_next;
        b_nan_reg   <= b_nan_next;
        a_m_reg     <= a_m_next;
        b_m_reg     <= b_m_next;
        sh_reg      <= sh_next;
        acc_reg     <= acc_next;
        mcand_reg   <= mcand_next;
        mplier_reg  <= mplier_next;
        la_reg      <= la_next;
        lb_reg      <= lb_next;
        r_neg_reg   <= r_neg_next;
        r_ovf_reg   <= r_ovf_next;
        r_nan_reg   <= r_nan_next;
        r_m_reg     <= r_m_next;
        rem_neg_reg <= rem_neg_next;
        rem_m_reg   <= rem_m_next;
        ord_reg     <= ord_next;
        m_tdata_reg <= m_tdata_next;
    end

endmodule
